// ----- sv/rrts_pkg.sv -----
package rrts_pkg;

    localparam int unsigned ID_W     = 4;
    localparam int unsigned KIND_W   = 3;
    localparam int unsigned SLICE_W  = 8;
    localparam int unsigned QCNT_W   = 5;
    localparam int unsigned STATUS_W = 2;

    localparam int unsigned IN_DATA_W  = 8;
    localparam int unsigned IN_USER_W  = 3;
    localparam int unsigned OUT_DATA_W = 24;

    localparam logic [KIND_W-1:0] KIND_TICK   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_ADD    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd2;
    localparam logic [KIND_W-1:0] KIND_YIELD  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_STOP   = 3'd4;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;

    localparam logic [SLICE_W-1:0] SLICE_TICKS_RESET = 8'd10;

    localparam logic [2:0] ADDR_SLICE_TICKS = 3'd0;
    localparam logic [2:0] ADDR_ENABLED     = 3'd4;

    typedef enum logic [0:0] {
        S_IDLE,
        S_SCAN
    } state_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [QCNT_W-1:0]   queue_count;
        logic [ID_W-1:0]     previous_id;
        logic                previous_valid;
        logic                switched;
        logic [ID_W-1:0]     running_id;
        logic                running_valid;
    } result_t;

endpackage

// ----- sv/rrts_cell.sv -----
module rrts_cell #(
    parameter int unsigned IDX   = 0,
    parameter int unsigned IDX_W = 4
) (
    input  logic                      clk,
    input  logic                      shift,
    input  logic                      wr_en,
    input  logic [IDX_W-1:0]          wr_pos,
    input  logic [rrts_pkg::ID_W-1:0] wr_data,
    input  logic [rrts_pkg::ID_W-1:0] next_slot,
    output logic [rrts_pkg::ID_W-1:0] slot
);

    logic [rrts_pkg::ID_W-1:0] slot_reg;
    logic [rrts_pkg::ID_W-1:0] slot_next;

    always_comb
    begin
        if (wr_en && (wr_pos == IDX_W'(IDX)))
        begin
            slot_next = wr_data;
        end
        else if (shift)
        begin
            slot_next = next_slot;
        end
        else
        begin
            slot_next = slot_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
    end

    assign slot = slot_reg;

endmodule

// ----- sv/rrts_queue.sv -----
module rrts_queue #(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned IDX_W = 4
) (
    input  logic                      clk,
    input  logic                      shift,
    input  logic                      wr_en,
    input  logic [IDX_W-1:0]          wr_pos,
    input  logic [rrts_pkg::ID_W-1:0] wr_data,
    output logic [rrts_pkg::ID_W-1:0] head
);

    logic [rrts_pkg::ID_W-1:0] slots [DEPTH];

    // shift moves every entry one cell toward the head; a write wins over the shift
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [rrts_pkg::ID_W-1:0] from_right;

        if (i == DEPTH - 1)
        begin : g_last
            assign from_right = '0;
        end
        else
        begin : g_mid
            assign from_right = slots[i+1];
        end

        rrts_cell #(
            .IDX   (i),
            .IDX_W (IDX_W)
        ) u_cell (
            .clk       (clk),
            .shift     (shift),
            .wr_en     (wr_en),
            .wr_pos    (wr_pos),
            .wr_data   (wr_data),
            .next_slot (from_right),
            .slot      (slots[i])
        );
    end

    assign head = slots[0];

endmodule

// ----- sv/round_robin_time_slice_scheduler.sv -----
// Round-robin scheduler with time slice. Events enter on the s_ side (kind in tuser,
// task id in tdata), one status record per event leaves on the m_ side. Tick, add,
// yield, stop and a remove on an empty queue are handled in the accepting cycle; the
// record is registered and the next event is taken in the following cycle as long as
// the output register is free or drained. A remove on a non-empty queue goes through
// the accepting cycle, a rotation of the ready queue once through the chain of slot
// cells that drops the first match on the way, and a final step that registers the
// record once the output register is free. The user writes slice_ticks (0x0) and
// enabled (0x4) over APB only while no event is open; the block does not enforce it.
module round_robin_time_slice_scheduler #(
    parameter int unsigned MAX_TASKS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [rrts_pkg::IN_DATA_W-1:0]      s_tdata,   // [3:0] proc_id
    input  logic [rrts_pkg::IN_USER_W-1:0]      s_tuser,   // [2:0] kind

    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [0] running_valid, [4:1] running_id, [5] switched, [6] previous_valid,
    // [10:7] previous_id, [15:11] queue_count, [17:16] status
    output logic [rrts_pkg::OUT_DATA_W-1:0]     m_tdata,

    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [2:0]                          paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    localparam int unsigned IDX_W = $clog2(MAX_TASKS);
    localparam int unsigned CNT_W = $clog2(MAX_TASKS + 1);

    localparam int unsigned ID_W    = rrts_pkg::ID_W;
    localparam int unsigned SLICE_W = rrts_pkg::SLICE_W;

    // configuration
    logic [SLICE_W-1:0] slice_ticks_reg;
    logic               enabled_reg;
    logic               cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slice_ticks_reg <= rrts_pkg::SLICE_TICKS_RESET;
            enabled_reg     <= 1'b0;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == rrts_pkg::ADDR_ENABLED[2])
            begin
                enabled_reg <= pwdata[0];
            end
            else
            begin
                slice_ticks_reg <= pwdata[SLICE_W-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == rrts_pkg::ADDR_ENABLED[2]) ? {31'd0, enabled_reg}
                                                             : {24'd0, slice_ticks_reg};

    // state
    rrts_pkg::state_t     state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CNT_W-1:0]     steps_reg, steps_next;
    logic                 found_reg, found_next;
    logic [ID_W-1:0]      rm_id_reg, rm_id_next;
    logic [ID_W-1:0]      cur_id_reg, cur_id_next;
    logic                 cur_valid_reg, cur_valid_next;
    logic                 cur_active_reg, cur_active_next;
    logic [SLICE_W-1:0]   slice_left_reg, slice_left_next;
    logic                 out_valid_reg, out_valid_next;
    rrts_pkg::result_t    out_data_reg, out_data_next;

    // queue control
    logic                 q_shift;
    logic                 q_wr_en;
    logic [CNT_W-1:0]     q_wr_pos;
    logic [ID_W-1:0]      q_wr_data;
    logic [ID_W-1:0]      q_head;

    logic                 in_xfer;
    logic                 out_free;
    logic [2:0]           kind;
    logic [ID_W-1:0]      pid;
    logic                 scan_done;

    assign kind      = s_tuser[2:0];
    assign pid       = s_tdata[ID_W-1:0];
    assign out_free  = !out_valid_reg || m_tready;
    assign s_tready  = (state_reg == rrts_pkg::S_IDLE) && out_free;
    assign in_xfer   = s_tvalid && s_tready;
    assign scan_done = (steps_reg == '0);

    rrts_queue #(
        .DEPTH (MAX_TASKS),
        .IDX_W (IDX_W)
    ) u_queue (
        .clk     (clk),
        .shift   (q_shift),
        .wr_en   (q_wr_en),
        .wr_pos  (q_wr_pos[IDX_W-1:0]),
        .wr_data (q_wr_data),
        .head    (q_head)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rrts_pkg::S_IDLE:
            begin
                if (in_xfer && (kind == rrts_pkg::KIND_REMOVE) && (count_reg != '0))
                begin
                    state_next = rrts_pkg::S_SCAN;
                end
            end
            rrts_pkg::S_SCAN:
            begin
                if (scan_done && out_free)
                begin
                    state_next = rrts_pkg::S_IDLE;
                end
            end
            default: state_next = rrts_pkg::S_IDLE;
        endcase
    end

    // datapath
    always_comb
    begin
        logic               do_sched;
        logic               keep_old;
        logic [SLICE_W-1:0] slice_eff;
        logic               load_out;
        logic               sw;
        logic               prev_valid;
        logic [ID_W-1:0]    prev_id;
        logic [1:0]         status;

        count_next      = count_reg;
        steps_next      = steps_reg;
        found_next      = found_reg;
        rm_id_next      = rm_id_reg;
        cur_id_next     = cur_id_reg;
        cur_valid_next  = cur_valid_reg;
        cur_active_next = cur_active_reg;
        slice_left_next = slice_left_reg;
        q_shift         = 1'b0;
        q_wr_en         = 1'b0;
        q_wr_pos        = count_reg;
        q_wr_data       = pid;
        do_sched        = 1'b0;
        keep_old        = cur_valid_reg && cur_active_reg;
        slice_eff       = slice_left_reg;
        load_out        = 1'b0;
        sw              = 1'b0;
        prev_valid      = 1'b0;
        prev_id         = '0;
        status          = rrts_pkg::STATUS_OK;

        if (state_reg == rrts_pkg::S_IDLE)
        begin
            if (in_xfer)
            begin
                load_out = 1'b1;
                unique case (kind)
                    rrts_pkg::KIND_TICK:
                    begin
                        do_sched = enabled_reg;
                    end
                    rrts_pkg::KIND_ADD:
                    begin
                        if (count_reg == CNT_W'(MAX_TASKS))
                        begin
                            status = rrts_pkg::STATUS_FULL;
                        end
                        else
                        begin
                            q_wr_en    = 1'b1;
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    rrts_pkg::KIND_REMOVE:
                    begin
                        if (count_reg == '0)
                        begin
                            status = rrts_pkg::STATUS_NOT_FOUND;
                        end
                        else
                        begin
                            load_out   = 1'b0;
                            steps_next = count_reg;
                            found_next = 1'b0;
                            rm_id_next = pid;
                        end
                    end
                    rrts_pkg::KIND_YIELD:
                    begin
                        do_sched = 1'b1;
                        if (cur_valid_reg)
                        begin
                            slice_eff = '0;
                        end
                    end
                    rrts_pkg::KIND_STOP:
                    begin
                        cur_active_next = 1'b0;
                    end
                    default:
                    begin
                    end
                endcase

                if (do_sched)
                begin
                    slice_left_next = slice_eff;
                    if (count_reg != '0)
                    begin
                        if (keep_old && (slice_eff != '0))
                        begin
                            slice_left_next = slice_eff - SLICE_W'(1);
                        end
                        else
                        begin
                            // dequeue head, requeue the old task at the freed tail slot if it is still active
                            q_shift   = 1'b1;
                            q_wr_pos  = count_reg - CNT_W'(1);
                            q_wr_data = cur_id_reg;
                            if (keep_old)
                            begin
                                q_wr_en = 1'b1;
                            end
                            else
                            begin
                                count_next = count_reg - CNT_W'(1);
                            end
                            sw              = 1'b1;
                            prev_valid      = cur_valid_reg;
                            prev_id         = cur_valid_reg ? cur_id_reg : '0;
                            cur_id_next     = q_head;
                            cur_valid_next  = 1'b1;
                            cur_active_next = 1'b1;
                            slice_left_next = slice_ticks_reg;
                        end
                    end
                end
            end
        end
        else
        begin
            if (!scan_done)
            begin
                // rotate: head leaves cell 0 and re-enters at the tail unless it is
                // the first match
                q_shift    = 1'b1;
                steps_next = steps_reg - CNT_W'(1);
                q_wr_pos   = count_reg - CNT_W'(1);
                q_wr_data  = q_head;
                if (!found_reg && (q_head == rm_id_reg))
                begin
                    found_next = 1'b1;
                    count_next = count_reg - CNT_W'(1);
                end
                else
                begin
                    q_wr_en = 1'b1;
                end
            end
            else if (out_free)
            begin
                load_out = 1'b1;
                status   = found_reg ? rrts_pkg::STATUS_OK : rrts_pkg::STATUS_NOT_FOUND;
            end
        end

        out_data_next.running_valid  = cur_valid_next;
        out_data_next.running_id     = cur_valid_next ? cur_id_next : '0;
        out_data_next.switched       = sw;
        out_data_next.previous_valid = prev_valid;
        out_data_next.previous_id    = prev_id;
        out_data_next.queue_count    = rrts_pkg::QCNT_W'(count_next);
        out_data_next.status         = status;

        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && !m_tready;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= rrts_pkg::S_IDLE;
            count_reg      <= '0;
            steps_reg      <= '0;
            found_reg      <= 1'b0;
            cur_id_reg     <= '0;
            cur_valid_reg  <= 1'b0;
            cur_active_reg <= 1'b0;
            slice_left_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            steps_reg      <= steps_next;
            found_reg      <= found_next;
            cur_id_reg     <= cur_id_next;
            cur_valid_reg  <= cur_valid_next;
            cur_active_reg <= cur_active_next;
            slice_left_reg <= slice_left_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rm_id_reg <= rm_id_next;
        if (out_valid_next && !(out_valid_reg && !m_tready))
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_data_reg};

endmodule

// ----- test/testbench.sv -----
module testbench;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned PHASES      = 12;
    localparam int unsigned PHASE_ITEMS = 160;
    localparam int unsigned MAX_READY   = 16;
    localparam int unsigned ID_W        = rrts_pkg::ID_W;
    localparam int unsigned KIND_W      = rrts_pkg::KIND_W;
    localparam int unsigned SLICE_W     = rrts_pkg::SLICE_W;
    localparam logic [KIND_W-1:0] KIND_UNUSED = rrts_pkg::KIND_STOP + 3'd1;

    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0]   pid;
    } sched_event_t;

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;   // [3:0] proc_id
    logic [2:0]  s_tuser  = '0;   // [2:0] kind
    logic        m_tvalid;
    logic        m_tready = 1'b1;
    // [0] running_valid, [4:1] running_id, [5] switched, [6] previous_valid,
    // [10:7] previous_id, [15:11] queue_count, [17:16] status
    logic [23:0] m_tdata;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    round_robin_time_slice_scheduler u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // scheduler state as the testbench sees it
    logic [ID_W-1:0]    ready_ids [MAX_READY];
    int unsigned        ready_len    = 0;
    logic [ID_W-1:0]    cur_id       = '0;
    logic               cur_valid    = 1'b0;
    logic               cur_active   = 1'b0;
    logic [SLICE_W-1:0] slice_left   = '0;
    logic [SLICE_W-1:0] cfg_slice    = rrts_pkg::SLICE_TICKS_RESET;
    logic               cfg_enabled  = 1'b0;

    sched_event_t      pending [$];
    rrts_pkg::result_t sched_results [$];

    int unsigned cycle_count = 0;
    int unsigned failures    = 0;
    int unsigned src_wait    = 0;
    int unsigned snk_wait    = 0;
    bit          src_calm    = 1'b0;
    bit          snk_calm    = 1'b0;

    function automatic bit ready_push(logic [ID_W-1:0] id);
        if (ready_len >= MAX_READY)
            return 1'b0;
        ready_ids[ready_len] = id;
        ready_len++;
        return 1'b1;
    endfunction

    // drops the match nearest the head and closes the gap
    function automatic bit ready_drop(logic [ID_W-1:0] id);
        for (int i = 0; i < ready_len; i++)
        begin
            if (ready_ids[i] == id)
            begin
                for (int j = i; j + 1 < ready_len; j++)
                    ready_ids[j] = ready_ids[j + 1];
                ready_len--;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic void take_turn(inout rrts_pkg::result_t r);
        bit              keep_old;
        logic [ID_W-1:0] head;
        if (ready_len == 0)
            return;
        keep_old = cur_valid && cur_active;
        if (keep_old && slice_left != 0)
        begin
            slice_left--;
            return;
        end
        head = ready_ids[0];
        void'(ready_drop(head));
        if (keep_old)
            void'(ready_push(cur_id));
        r.switched       = 1'b1;
        r.previous_valid = cur_valid;
        r.previous_id    = cur_valid ? cur_id : '0;
        cur_id     = head;
        cur_valid  = 1'b1;
        cur_active = 1'b1;
        slice_left = cfg_slice;
    endfunction

    function automatic rrts_pkg::result_t schedule_event(logic [KIND_W-1:0] kind,
                                                         logic [ID_W-1:0]   pid);
        rrts_pkg::result_t r;
        r = '0;
        r.status = rrts_pkg::STATUS_OK;
        case (kind)
            rrts_pkg::KIND_TICK:
                if (cfg_enabled)
                    take_turn(r);
            rrts_pkg::KIND_ADD:
                if (!ready_push(pid))
                    r.status = rrts_pkg::STATUS_FULL;
            rrts_pkg::KIND_REMOVE:
                if (!ready_drop(pid))
                    r.status = rrts_pkg::STATUS_NOT_FOUND;
            rrts_pkg::KIND_YIELD:
            begin
                if (cur_valid)
                    slice_left = '0;
                take_turn(r);
            end
            rrts_pkg::KIND_STOP:
                cur_active = 1'b0;
            default:
                ;
        endcase
        r.running_valid = cur_valid;
        r.running_id    = cur_valid ? cur_id : '0;
        r.queue_count   = rrts_pkg::QCNT_W'(ready_len);
        return r;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // event driver
    always @(posedge clk)
    begin
        sched_event_t ev;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sched_results.push_back(schedule_event(s_tuser, s_tdata[ID_W-1:0]));
            if (!s_tvalid || s_tready)
            begin
                if (src_wait > 0)
                begin
                    src_wait--;
                    s_tvalid <= 1'b0;
                end
                else if (pending.size() > 0)
                begin
                    ev = pending.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {4'b0, ev.pid};
                    s_tuser  <= ev.kind;
                    if ($urandom_range(0, 31) == 0)
                        src_calm = !src_calm;
                    src_wait = src_calm ? 0 : $urandom_range(0, 12);
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // result monitor and checker
    always @(posedge clk)
    begin
        rrts_pkg::result_t got;
        rrts_pkg::result_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got = rrts_pkg::result_t'(m_tdata[$bits(rrts_pkg::result_t)-1:0]);
                if (sched_results.size() == 0)
                begin
                    if (failures < 10)
                        $display("unexpected transfer: data %h", m_tdata);
                    failures++;
                end
                else
                begin
                    want = sched_results.pop_front();
                    if (got.running_valid !== want.running_valid ||
                        got.running_id !== want.running_id ||
                        got.switched !== want.switched ||
                        got.previous_valid !== want.previous_valid ||
                        got.previous_id !== want.previous_id ||
                        got.queue_count !== want.queue_count ||
                        got.status !== want.status)
                    begin
                        if (failures < 10)
                        begin
                            $write("mismatch: exp rv %0d id %0d sw %0d pv %0d pid %0d cnt %0d st %0d",
                                   want.running_valid, want.running_id, want.switched,
                                   want.previous_valid, want.previous_id, want.queue_count,
                                   want.status);
                            $display(" / got rv %0d id %0d sw %0d pv %0d pid %0d cnt %0d st %0d",
                                     got.running_valid, got.running_id, got.switched,
                                     got.previous_valid, got.previous_id, got.queue_count,
                                     got.status);
                        end
                        failures++;
                    end
                end
                if ($urandom_range(0, 31) == 0)
                    snk_calm = !snk_calm;
                snk_wait = snk_calm ? 0 : $urandom_range(0, 12);
                m_tready <= (snk_wait == 0);
            end
            else if (snk_wait > 0)
            begin
                snk_wait--;
                m_tready <= (snk_wait == 0);
            end
        end
    end

    task automatic queue_event(logic [KIND_W-1:0] kind, logic [ID_W-1:0] pid);
        sched_event_t ev;
        ev.kind = kind;
        ev.pid  = pid;
        pending.push_back(ev);
    endtask

    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (addr)
            rrts_pkg::ADDR_SLICE_TICKS: cfg_slice   = data[SLICE_W-1:0];
            rrts_pkg::ADDR_ENABLED:     cfg_enabled = data[0];
            default:                    ;
        endcase
    endtask

    task automatic wait_drained();
        @(negedge clk);
        while (pending.size() != 0 || s_tvalid || sched_results.size() != 0)
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        logic [SLICE_W-1:0] slices [PHASES];
        logic [KIND_W-1:0]  kind;
        logic [ID_W-1:0]    pid;
        int unsigned        roll;
        int unsigned        p_add, p_rem, p_tick, p_yield, p_stop;

        slices = '{8'd0, 8'd255, 8'd1, 8'd3, 8'd0, 8'd2, 8'd255, 8'd1, 8'd4, 8'd0, 8'd6, 8'd1};
        slices[9] = SLICE_W'($urandom_range(0, 255));

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed run with reset settings (slice 10, ticks disabled)
        queue_event(rrts_pkg::KIND_TICK, 4'd3);
        queue_event(rrts_pkg::KIND_YIELD, 4'd0);
        queue_event(rrts_pkg::KIND_STOP, 4'd0);
        queue_event(rrts_pkg::KIND_REMOVE, 4'd7);
        queue_event(KIND_UNUSED, 4'd15);
        queue_event(KIND_UNUSED + 3'd1, 4'd1);
        queue_event(KIND_UNUSED + 3'd2, 4'd2);
        queue_event(rrts_pkg::KIND_ADD, 4'd15);
        queue_event(rrts_pkg::KIND_ADD, 4'd0);
        queue_event(rrts_pkg::KIND_ADD, 4'd15);
        queue_event(rrts_pkg::KIND_YIELD, 4'd0);
        queue_event(rrts_pkg::KIND_ADD, 4'd15);      // current id queued again
        queue_event(rrts_pkg::KIND_REMOVE, 4'd15);   // duplicate: nearest the head goes
        queue_event(rrts_pkg::KIND_REMOVE, 4'd9);
        queue_event(rrts_pkg::KIND_TICK, 4'd0);
        queue_event(rrts_pkg::KIND_YIELD, 4'd0);
        queue_event(rrts_pkg::KIND_STOP, 4'd0);
        queue_event(rrts_pkg::KIND_YIELD, 4'd0);     // stopped task is not re-queued
        queue_event(rrts_pkg::KIND_ADD, 4'd10);
        queue_event(rrts_pkg::KIND_ADD, 4'd5);
        queue_event(rrts_pkg::KIND_YIELD, 4'd0);
        queue_event(rrts_pkg::KIND_REMOVE, 4'd15);
        wait_drained();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            apb_write(rrts_pkg::ADDR_SLICE_TICKS, {24'b0, slices[ph]});
            apb_write(rrts_pkg::ADDR_ENABLED, {31'b0, (ph % 6) != 5});
            case (ph % 3)
                0:       begin p_add = 25; p_rem = 15; p_tick = 35; p_yield = 10; p_stop = 10; end
                1:       begin p_add = 55; p_rem = 10; p_tick = 15; p_yield = 10; p_stop = 6;  end
                default: begin p_add = 15; p_rem = 35; p_tick = 20; p_yield = 18; p_stop = 8;  end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < p_add)
                    kind = rrts_pkg::KIND_ADD;
                else if (roll < p_add + p_rem)
                    kind = rrts_pkg::KIND_REMOVE;
                else if (roll < p_add + p_rem + p_tick)
                    kind = rrts_pkg::KIND_TICK;
                else if (roll < p_add + p_rem + p_tick + p_yield)
                    kind = rrts_pkg::KIND_YIELD;
                else if (roll < p_add + p_rem + p_tick + p_yield + p_stop)
                    kind = rrts_pkg::KIND_STOP;
                else
                    kind = KIND_UNUSED + KIND_W'($urandom_range(0, 2));
                // a narrow id pool makes removes hit often
                pid = $urandom_range(0, 1) ? ID_W'($urandom_range(0, 3))
                                           : ID_W'($urandom_range(0, 15));
                queue_event(kind, pid);
            end
            wait_drained();
        end

        repeat (20) @(posedge clk);
        if (failures == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/rrts_pkg.sv
sv/rrts_cell.sv
sv/rrts_queue.sv
sv/round_robin_time_slice_scheduler.sv
test/testbench.sv
